// ===== sv/sequence_convolution_top_defines.svh =====
`ifndef SEQUENCE_CONVOLUTION_TOP_DEFINES_SVH
`define SEQUENCE_CONVOLUTION_TOP_DEFINES_SVH

// same-cycle implication
`define SCONV_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SCONV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sconv_pkg.sv =====
package sconv_pkg;

  localparam int unsigned ElemW = 16;
  localparam int unsigned ProdW = 32;
  localparam int unsigned SumW  = 37;

  typedef enum logic {
    OP_TAP    = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_EMIT,
    ST_FL_RD,
    ST_FL_EMIT
  } state_e;

  typedef struct packed {
    logic tap_wr;
    logic smp_load;
    logic mac_issue;
    logic emit_y;
    logic fl_emit;
    logic run_clr;
  } cmd_t;

  typedef struct packed {
    logic taps_done;
    logic k_at_end;
    logic single;
    logic smp_last;
    logic flush_end;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/sconv_in_if.sv =====
interface sconv_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   operation;
  logic signed [sconv_pkg::ElemW-1:0]     element_value;
  logic                                   is_last;

  modport source (output valid, output operation, output element_value, output is_last,
                  input ready);
  modport sink   (input valid, input operation, input element_value, input is_last,
                  output ready);
endinterface

// ===== sv/sconv_out_if.sv =====
interface sconv_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [sconv_pkg::SumW-1:0]     sum_value;
  logic                                  last_of_run;

  modport source (output valid, output sum_value, output last_of_run, input ready);
  modport sink   (input valid, input sum_value, input last_of_run, output ready);
endinterface

// ===== sv/sconv_dp.sv =====
module sconv_dp #(
  parameter int unsigned MAX_TAPS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sconv_pkg::cmd_t                     cmd_i,
  output sconv_pkg::sts_t                     sts_o,
  input  logic signed [sconv_pkg::ElemW-1:0]  element_value_i,
  input  logic                                is_last_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [sconv_pkg::SumW-1:0]   sum_value_o,
  output logic                                last_of_run_o
);

  localparam int unsigned IdxW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int unsigned CntW = $clog2(MAX_TAPS + 1);

  logic signed [sconv_pkg::ElemW-1:0] tap_mem [MAX_TAPS];
  logic signed [sconv_pkg::SumW-1:0]  ps_mem  [MAX_TAPS];
  logic [MAX_TAPS-1:0]                ps_vld_q;

  logic [CntW-1:0] tap_count_q;
  logic            taps_done_q;
  logic [IdxW-1:0] k_q;
  logic [CntW-1:0] n_m1;
  logic            tap_room;
  logic            flush_end;

  logic signed [sconv_pkg::ElemW-1:0] x_q;
  logic                               last_q;
  logic signed [sconv_pkg::ElemW-1:0] tap_rd_q;
  logic signed [sconv_pkg::SumW-1:0]  ps_rd_q;
  logic                               ps_vld_rd_q;
  logic signed [sconv_pkg::SumW-1:0]  ps_rd_eff;

  logic                               v1_q, v2_q;
  logic [IdxW-1:0]                    idx1_q, idx2_q;
  logic signed [sconv_pkg::ProdW-1:0] prod_q;
  logic signed [sconv_pkg::SumW-1:0]  ps2_q;
  logic signed [sconv_pkg::SumW-1:0]  sum3;
  logic                               ps_we;
  logic [IdxW-1:0]                    ps_wa;
  logic                               ps_end;
  logic signed [sconv_pkg::SumW-1:0]  y_q;

  logic                               out_valid_q;
  logic signed [sconv_pkg::SumW-1:0]  out_sum_q;
  logic                               out_last_q;
  logic                               out_free;

  assign n_m1      = tap_count_q - CntW'(1);
  assign tap_room  = tap_count_q < CntW'(MAX_TAPS);
  assign flush_end = ((CntW+1)'(k_q) + (CntW+1)'(2)) == (CntW+1)'(tap_count_q);
  assign ps_rd_eff = ps_vld_rd_q ? ps_rd_q : '0;
  assign sum3      = ps2_q + sconv_pkg::SumW'(prod_q);
  assign ps_we     = v2_q && (idx2_q != '0);
  assign ps_wa     = idx2_q - IdxW'(1);
  assign ps_end    = v2_q && (CntW'(idx2_q) == n_m1);
  assign out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= '0;
      taps_done_q <= 1'b0;
    end else if (cmd_i.run_clr) begin
      tap_count_q <= '0;
      taps_done_q <= 1'b0;
    end else if (cmd_i.tap_wr) begin
      if (tap_room) begin
        tap_count_q <= tap_count_q + CntW'(1);
      end
      if (is_last_i) begin
        taps_done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (cmd_i.smp_load || cmd_i.emit_y) begin
      k_q <= '0;
    end else if (cmd_i.mac_issue || cmd_i.fl_emit) begin
      k_q <= k_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.smp_load) begin
      x_q    <= element_value_i;
      last_q <= is_last_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tap_wr && tap_room) begin
      tap_mem[tap_count_q[IdxW-1:0]] <= element_value_i;
    end
    tap_rd_q <= tap_mem[k_q];
  end

  always_ff @(posedge clk_i) begin
    if (ps_we) begin
      ps_mem[ps_wa] <= sum3;
    end
    ps_rd_q     <= ps_mem[k_q];
    ps_vld_rd_q <= ps_vld_q[k_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_vld_q <= '0;
    end else if (cmd_i.run_clr) begin
      ps_vld_q <= '0;
    end else begin
      if (ps_we) begin
        ps_vld_q[ps_wa] <= 1'b1;
      end
      if (ps_end) begin
        ps_vld_q[idx2_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.mac_issue;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q <= k_q;
    idx2_q <= idx1_q;
    prod_q <= sconv_pkg::ProdW'(x_q) * sconv_pkg::ProdW'(tap_rd_q);
    ps2_q  <= ps_rd_eff;
    if (v2_q && (idx2_q == '0)) begin
      y_q <= sum3;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_y || cmd_i.fl_emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_y) begin
      out_sum_q  <= y_q;
      out_last_q <= last_q && (tap_count_q == CntW'(1));
    end else if (cmd_i.fl_emit) begin
      out_sum_q  <= ps_rd_eff;
      out_last_q <= flush_end;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign sum_value_o   = out_sum_q;
  assign last_of_run_o = out_last_q;

  always_comb begin
    sts_o.taps_done = taps_done_q;
    sts_o.k_at_end  = CntW'(k_q) == n_m1;
    sts_o.single    = tap_count_q == CntW'(1);
    sts_o.smp_last  = last_q;
    sts_o.flush_end = flush_end;
    sts_o.out_free  = out_free;
  end

endmodule

// ===== sv/sconv_ctrl.sv =====
module sconv_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            operation_i,
  output logic            in_ready_o,
  input  sconv_pkg::sts_t sts_i,
  output sconv_pkg::cmd_t cmd_o
);

  sconv_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sconv_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      sconv_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (operation_i == sconv_pkg::OP_TAP) begin
            cmd_o.tap_wr = !sts_i.taps_done;
          end else if (sts_i.taps_done) begin
            cmd_o.smp_load = 1'b1;
            state_d        = sconv_pkg::ST_MAC;
          end
        end
      end
      sconv_pkg::ST_MAC: begin
        cmd_o.mac_issue = 1'b1;
        if (sts_i.k_at_end) begin
          state_d = sconv_pkg::ST_DRAIN1;
        end
      end
      sconv_pkg::ST_DRAIN1: begin
        state_d = sconv_pkg::ST_DRAIN2;
      end
      sconv_pkg::ST_DRAIN2: begin
        state_d = sconv_pkg::ST_EMIT;
      end
      sconv_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_y = 1'b1;
          if (!sts_i.smp_last) begin
            state_d = sconv_pkg::ST_IDLE;
          end else if (sts_i.single) begin
            cmd_o.run_clr = 1'b1;
            state_d       = sconv_pkg::ST_IDLE;
          end else begin
            state_d = sconv_pkg::ST_FL_RD;
          end
        end
      end
      sconv_pkg::ST_FL_RD: begin
        state_d = sconv_pkg::ST_FL_EMIT;
      end
      sconv_pkg::ST_FL_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.fl_emit = 1'b1;
          if (sts_i.flush_end) begin
            cmd_o.run_clr = 1'b1;
            state_d       = sconv_pkg::ST_IDLE;
          end else begin
            state_d = sconv_pkg::ST_FL_RD;
          end
        end
      end
      default: begin
        state_d = sconv_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/sequence_convolution_top.sv =====
// channel  | dir | payload                                | beat
// in_i     | in  | operation, element_value, is_last      | one tap or one sample
// out_o    | out | sum_value, last_of_run                 | one convolution output
//
// A tap beat is taken while idle. A sample beat with n stored taps steps all n
// through the single multiplier and the one-read-port partial-sum memory, plus the output slot.
// Last sample: each flushed result takes a memory read, then an output load.
// Reset clears counters, valid bits and the controller; tap storage is not cleared.
// in_i.ready is high only while idle; a stalled out_o holds the controller in place.
module sequence_convolution_top #(
  parameter int unsigned MAX_TAPS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sconv_in_if.sink    in_i,
  sconv_out_if.source out_o
);

  sconv_pkg::cmd_t cmd;
  sconv_pkg::sts_t sts;
  logic            in_ready;

  sconv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .operation_i (in_i.operation),
    .in_ready_o  (in_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sconv_dp #(
    .MAX_TAPS (MAX_TAPS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .element_value_i (in_i.element_value),
    .is_last_i       (in_i.is_last),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .sum_value_o     (out_o.sum_value),
    .last_of_run_o   (out_o.last_of_run)
  );

  assign in_i.ready = in_ready;

endmodule

// ===== sv/sconv_chk.sv =====
`include "sequence_convolution_top_defines.svh"

module sconv_chk (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_i,
  input logic                               in_operation_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic signed [sconv_pkg::SumW-1:0]  out_sum_i,
  input logic                               out_last_i
);

  `SCONV_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "stalled output beat dropped")
  `SCONV_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_sum_i) && $stable(out_last_i), "stalled output beat changed")
  `SCONV_ASSERT_NOW(a_load_busy, clk_i, rst_ni, $rose(out_valid_i), !$past(in_ready_i), "output loaded while input side idle")
  `SCONV_ASSERT_NEXT(a_tap_quiet, clk_i, rst_ni, in_valid_i && in_ready_i && (in_operation_i == sconv_pkg::OP_TAP), !$rose(out_valid_i), "tap beat produced a result")

endmodule

bind sequence_convolution_top sconv_chk u_sconv_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_operation_i (in_i.operation),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_sum_i      (out_o.sum_value),
  .out_last_i     (out_o.last_of_run)
);

// ===== tb/sequence_convolution_top_tb.sv =====
`timescale 1ns / 1ps

module sequence_convolution_top_tb;

  localparam int unsigned MaxTaps    = 32;
  localparam int unsigned RandItems  = 150;
  localparam int unsigned DrainWait  = 2 * MaxTaps + 40;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned NumRows    = 23;

  typedef enum int {
    RX_OPEN,
    RX_CHOPPY,
    RX_CHOKED
  } rx_mode_e;

  typedef struct packed {
    logic signed [sconv_pkg::SumW-1:0] sum_value;
    logic                              last_of_run;
  } conv_out_t;

  typedef struct packed {
    sconv_pkg::op_e                     op;
    logic signed [sconv_pkg::ElemW-1:0] value;
    logic                               last;
    logic                               typed;
    logic signed [sconv_pkg::SumW-1:0]  t_sum;
    logic                               t_last;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  sconv_in_if  in_if ();
  sconv_out_if out_if ();

  sequence_convolution_top #(
    .MAX_TAPS(MaxTaps)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #5 clk_i = ~clk_i;

  logic signed [sconv_pkg::ElemW-1:0] tap_mem [MaxTaps];
  longint                             psum    [MaxTaps];
  int unsigned                        tap_cnt;
  logic                               taps_done;

  conv_out_t   sum_expect_q [$];
  conv_out_t   head_sum;
  stim_row_t   directed_rows [NumRows];
  int unsigned err_cnt;
  int unsigned out_cnt;
  int unsigned beat_cnt;
  int unsigned burst_left;
  int unsigned cycle_cnt;
  rx_mode_e    rx_mode;
  int unsigned rx_left;

  function automatic void clear_run();
    tap_cnt   = 0;
    taps_done = 1'b0;
    for (int k = 0; k < MaxTaps; k++) psum[k] = 0;
  endfunction

  function automatic void push_sum(longint s, logic l);
    conv_out_t e;
    e.sum_value   = s[sconv_pkg::SumW-1:0];
    e.last_of_run = l;
    sum_expect_q.push_back(e);
  endfunction

  function automatic void convolve_step(sconv_pkg::op_e op,
                                        logic signed [sconv_pkg::ElemW-1:0] x, logic last);
    int unsigned n;
    longint      y;
    if (op == sconv_pkg::OP_TAP) begin
      if (!taps_done) begin
        if (tap_cnt < MaxTaps) begin
          tap_mem[tap_cnt] = x;
          tap_cnt++;
        end
        if (last) taps_done = 1'b1;
      end
    end else if (taps_done) begin
      n = tap_cnt;
      y = psum[0] + longint'(x) * longint'(tap_mem[0]);
      for (int k = 1; k < n; k++) psum[k-1] = psum[k] + longint'(x) * longint'(tap_mem[k]);
      psum[n-1] = 0;
      push_sum(y, last && (n == 1));
      if (last) begin
        for (int k = 0; k + 1 < n; k++) push_sum(psum[k], (k + 2) == n);
        clear_run();
      end
    end
  endfunction

  function automatic logic signed [sconv_pkg::ElemW-1:0] rand_elem();
    case ($urandom_range(0, 7))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      3: return -16'sd1;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic drive_element(sconv_pkg::op_e op, logic signed [sconv_pkg::ElemW-1:0] val,
                               logic last, logic typed = 1'b0,
                               logic signed [sconv_pkg::SumW-1:0] t_sum = '0,
                               logic t_last = 1'b0);
    int unsigned gap;
    int unsigned idx;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_if.valid         <= 1'b1;
    in_if.operation     <= op;
    in_if.element_value <= val;
    in_if.is_last       <= last;
    do @(posedge clk_i); while (!in_if.ready);
    idx = sum_expect_q.size();
    convolve_step(op, val, last);
    if (typed) sum_expect_q[idx] = '{t_sum, t_last};
    burst_left--;
    beat_cnt++;
  endtask

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("cycle limit reached with %0d outputs outstanding", sum_expect_q.size());
      $display("sequence_convolution_top_tb: done, errors");
      $finish;
    end
  end

  // receiver: pick a stall mode for a random stretch
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 2));
        rx_left = $urandom_range(10, 80);
      end
      rx_left--;
      case (rx_mode)
        RX_OPEN:   out_if.ready <= 1'b1;
        RX_CHOPPY: out_if.ready <= 1'($urandom_range(0, 1));
        default:   out_if.ready <= $urandom_range(0, 3) == 0;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      out_cnt++;
      if (sum_expect_q.size() == 0) begin
        $error("unexpected output sum_value=%0d last_of_run=%0b",
               out_if.sum_value, out_if.last_of_run);
        err_cnt++;
      end else begin
        head_sum = sum_expect_q.pop_front();
        if (out_if.sum_value !== head_sum.sum_value) begin
          $error("sum_value: expected %0d, actual %0d", head_sum.sum_value, out_if.sum_value);
          err_cnt++;
        end
        if (out_if.last_of_run !== head_sum.last_of_run) begin
          $error("last_of_run: expected %0b, actual %0b",
                 head_sum.last_of_run, out_if.last_of_run);
          err_cnt++;
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned                        n_taps;
    int unsigned                        n_smps;
    int unsigned                        budget;
    int unsigned                        run_cnt;
    int unsigned                        dir_beats;
    logic signed [sconv_pkg::ElemW-1:0] v;

    err_cnt    = 0;
    out_cnt    = 0;
    beat_cnt   = 0;
    burst_left = 0;
    cycle_cnt  = 0;
    rx_mode    = RX_OPEN;
    rx_left    = 0;
    clear_run();
    for (int k = 0; k < MaxTaps; k++) tap_mem[k] = '0;

    rst_ni              = 1'b0;
    in_if.valid         = 1'b0;
    in_if.operation     = sconv_pkg::OP_TAP;
    in_if.element_value = '0;
    in_if.is_last       = 1'b0;
    out_if.ready        = 1'b0;

    directed_rows = '{
      '{sconv_pkg::OP_SAMPLE, 16'sh1234,    1'b0, 1'b0, 37'sd0, 1'b0},
      '{sconv_pkg::OP_SAMPLE, -16'sd1,      1'b1, 1'b0, 37'sd0, 1'b0},
      '{sconv_pkg::OP_TAP,    16'sd32767,   1'b1, 1'b0, 37'sd0, 1'b0},
      '{sconv_pkg::OP_TAP,    -16'sd32768,  1'b1, 1'b0, 37'sd0, 1'b0},
      '{sconv_pkg::OP_SAMPLE, -16'sd32768,  1'b0, 1'b1, -37'sd1073709056, 1'b0},
      '{sconv_pkg::OP_TAP,    16'sd5,       1'b0, 1'b0, 37'sd0, 1'b0},
      '{sconv_pkg::OP_SAMPLE, 16'sd32767,   1'b1, 1'b1, 37'sd1073676289, 1'b1},
      '{sconv_pkg::OP_TAP,    -16'sd32768,  1'b0, 1'b0, 37'sd0, 1'b0},
      '{sconv_pkg::OP_TAP,    -16'sd32768,  1'b1, 1'b0, 37'sd0, 1'b0},
      '{sconv_pkg::OP_SAMPLE, -16'sd32768,  1'b0, 1'b1, 37'sd1073741824, 1'b0},
      '{sconv_pkg::OP_SAMPLE, 16'sd32767,   1'b1, 1'b0, 37'sd0, 1'b0},
      '{sconv_pkg::OP_TAP,    16'sd0,       1'b0, 1'b0, 37'sd0, 1'b0},
      '{sconv_pkg::OP_TAP,    16'sd1,       1'b0, 1'b0, 37'sd0, 1'b0},
      '{sconv_pkg::OP_TAP,    -16'sd1,      1'b1, 1'b0, 37'sd0, 1'b0},
      '{sconv_pkg::OP_SAMPLE, 16'sd0,       1'b0, 1'b1, 37'sd0, 1'b0},
      '{sconv_pkg::OP_SAMPLE, 16'sd1,       1'b0, 1'b0, 37'sd0, 1'b0},
      '{sconv_pkg::OP_SAMPLE, -16'sd1,      1'b0, 1'b0, 37'sd0, 1'b0},
      '{sconv_pkg::OP_SAMPLE, 16'sh5555,    1'b0, 1'b0, 37'sd0, 1'b0},
      '{sconv_pkg::OP_SAMPLE, 16'shAAAA,    1'b1, 1'b0, 37'sd0, 1'b0},
      '{sconv_pkg::OP_TAP,    16'sh5555,    1'b0, 1'b0, 37'sd0, 1'b0},
      '{sconv_pkg::OP_TAP,    16'shAAAA,    1'b1, 1'b0, 37'sd0, 1'b0},
      '{sconv_pkg::OP_SAMPLE, 16'shAAAA,    1'b1, 1'b0, 37'sd0, 1'b0},
      '{sconv_pkg::OP_SAMPLE, 16'sd7,       1'b0, 1'b0, 37'sd0, 1'b0}
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      drive_element(directed_rows[i].op, directed_rows[i].value, directed_rows[i].last,
                    directed_rows[i].typed, directed_rows[i].t_sum, directed_rows[i].t_last);
    end
    dir_beats = beat_cnt;

    // first run: overfull tap set at full scale, one sample per stored tap
    budget  = 0;
    run_cnt = 0;
    while (budget < RandItems) begin
      if (run_cnt != 0 && $urandom_range(0, 4) == 0)
        drive_element(sconv_pkg::OP_SAMPLE, rand_elem(), 1'($urandom_range(0, 1)));
      if (run_cnt == 0) n_taps = MaxTaps + 2;
      else if ($urandom_range(0, 7) == 0) n_taps = $urandom_range(16, MaxTaps + 4);
      else n_taps = $urandom_range(1, 6);
      n_smps = (run_cnt == 0) ? MaxTaps : $urandom_range(1, 10);
      for (int t = 0; t < n_taps; t++) begin
        v = (run_cnt == 0) ? -16'sd32768 : rand_elem();
        drive_element(sconv_pkg::OP_TAP, v, t == n_taps - 1);
      end
      for (int s = 0; s < n_smps; s++) begin
        v = (run_cnt == 0) ? -16'sd32768 : rand_elem();
        if (s > 0 && $urandom_range(0, 9) == 0)
          drive_element(sconv_pkg::OP_TAP, rand_elem(), 1'($urandom_range(0, 1)));
        drive_element(sconv_pkg::OP_SAMPLE, v, s == n_smps - 1);
      end
      budget += n_taps + n_smps;
      run_cnt++;
    end
    in_if.valid <= 1'b0;

    while (sum_expect_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("covered %0d directed beats and %0d random beats over %0d random runs",
             dir_beats, beat_cnt - dir_beats, run_cnt);
    $display("checked %0d convolution outputs, %0d mismatches", out_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("sequence_convolution_top_tb: done, clean");
    end else begin
      $display("sequence_convolution_top_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/sconv_pkg.sv
sv/sconv_in_if.sv
sv/sconv_out_if.sv
sv/sconv_dp.sv
sv/sconv_ctrl.sv
sv/sequence_convolution_top.sv
sv/sconv_chk.sv
tb/sequence_convolution_top_tb.sv
